// ----- sv/wall_growth_stress_threshold_top_assert.svh -----
// Assertion macros for the wall growth stress threshold block.
`ifndef WALL_GROWTH_STRESS_THRESHOLD_TOP_ASSERT_SVH
`define WALL_GROWTH_STRESS_THRESHOLD_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WGST_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define WGST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WGST_ASSERT_SAME(lbl, ante, cons, msg)
`define WGST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/wgst_pkg.sv -----
// Package: widths, stage types and helpers for the wall growth pipeline.
`timescale 1ns / 1ps
package wgst_pkg;
    localparam int FRAC_BITS     = 16;
    localparam int MAX_FORCES    = 4;
    localparam int MAX_DIMENSION = 3;
    localparam int DATA_W  = 32;
    localparam int LEN_W   = 31;
    localparam int DIFF_W  = 33;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int Q_W     = 32;
    localparam int DREM_W  = 32;
    localparam int HI_W    = ROOT_W + FRAC_BITS - Q_W;
    localparam int SAT_W   = 72;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] CFG_GAIN      = 3'd0;
    localparam logic [IDX_W-1:0] CFG_THRESHOLD = 3'd1;
    localparam logic [IDX_W-1:0] CFG_STRETCH   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_SCALED    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_FCOUNT    = 3'd4;
    localparam logic [IDX_W-1:0] CFG_DIM       = 3'd5;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [LEN_W-1:0]         len;
        logic signed [DATA_W-1:0] deriv;
        logic signed [DATA_W-1:0] fsum;
    } ctx_t;

    typedef struct packed {
        ctx_t              ctx;
        logic [SUM_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    typedef struct packed {
        ctx_t              ctx;
        logic              neg;
        logic              ovf;
        logic [DREM_W-1:0] rem;
        logic [Q_W-1:0]    low;
        logic [Q_W-1:0]    q;
    } div_t;

    function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [SAT_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_W'(S32_MAX)) begin
            r = S32_MAX;
        end else if (v < SAT_W'(S32_MIN)) begin
            r = S32_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction
endpackage

// ----- sv/wgst_sqrt_cell.sv -----
// One root bit per cell: restoring square root step.
`timescale 1ns / 1ps
module wgst_sqrt_cell import wgst_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_vld,
    input  sqrt_t in_data,
    output logic  out_vld,
    output sqrt_t out_data
);
    logic              vld_reg;
    sqrt_t             data_reg;
    sqrt_t             data_next;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    always_comb begin
        rem_sh = {in_data.rem[REM_W-3:0], in_data.rad[SUM_W-1 -: 2]};
        trial  = {{(REM_W-ROOT_W-2){1'b0}}, in_data.root, 2'b01};
        ge     = rem_sh >= trial;
        data_next.ctx  = in_data.ctx;
        data_next.rad  = {in_data.rad[SUM_W-3:0], 2'b00};
        data_next.rem  = ge ? rem_sh - trial : rem_sh;
        data_next.root = {in_data.root[ROOT_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;
endmodule

// ----- sv/wgst_div_cell.sv -----
// One quotient bit per cell: restoring division by the wall length.
`timescale 1ns / 1ps
module wgst_div_cell import wgst_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic in_vld,
    input  div_t in_data,
    output logic out_vld,
    output div_t out_data
);
    logic              vld_reg;
    div_t              data_reg;
    div_t              data_next;
    logic [DREM_W-1:0] rem_sh;
    logic [DREM_W-1:0] dvs;
    logic              ge;

    always_comb begin
        rem_sh = {in_data.rem[DREM_W-2:0], in_data.low[Q_W-1]};
        dvs    = {{(DREM_W-LEN_W){1'b0}}, in_data.ctx.len};
        ge     = rem_sh >= dvs;
        data_next     = in_data;
        data_next.rem = ge ? rem_sh - dvs : rem_sh;
        data_next.low = {in_data.low[Q_W-2:0], 1'b0};
        data_next.q   = {in_data.q[Q_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;
endmodule

// ----- sv/wall_growth_stress_threshold_top.sv -----
// Top level: wall growth term from force sum or stretch, streaming pipeline.
`timescale 1ns / 1ps
// One wall per beat, one result per wall, accepted every cycle at full rate unless the skid stage
// is full. The datapath holds a row of 34 square root cells (one root bit each) and a row of 32
// divider cells (one quotient bit each). The pipeline stalls as a whole only when both the
// output register and its skid stage are full. Configuration is written through cfg_wr_*,
// by the user only while no wall is in flight; the block itself does not enforce this.
`include "wall_growth_stress_threshold_top_assert.svh"
module wall_growth_stress_threshold_top import wgst_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [IDX_W-1:0]   cfg_wr_index,
    input  logic [DATA_W-1:0]  cfg_wr_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    // wall_length, first_x, first_y, first_z, second_x, second_y, second_z,
    // force_a, force_b, force_c, force_d, deriv_in, zero pad
    input  logic [383:0]       s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // deriv_out, stress_value
    output logic [63:0]        m_tdata,
    // grew
    output logic               m_tuser
);
    localparam int NSQ  = ROOT_W;
    localparam int NDIV = Q_W;

    logic signed [DATA_W-1:0] gain_reg, thr_reg;
    logic                     stretch_reg, scaled_reg;
    logic [2:0]               fcount_reg;
    logic [1:0]               dim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg    <= 32'sd65536;
            thr_reg     <= '0;
            stretch_reg <= 1'b0;
            scaled_reg  <= 1'b0;
            fcount_reg  <= 3'd1;
            dim_reg     <= 2'd2;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_GAIN:      gain_reg    <= cfg_wr_data;
                CFG_THRESHOLD: thr_reg     <= cfg_wr_data;
                CFG_STRETCH:   stretch_reg <= cfg_wr_data[0];
                CFG_SCALED:    scaled_reg  <= cfg_wr_data[0];
                CFG_FCOUNT:    fcount_reg  <= cfg_wr_data[2:0];
                CFG_DIM:       dim_reg     <= cfg_wr_data[1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic out_valid_reg, skid_valid_reg;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // stage E0: differences and force sum
    logic signed [DATA_W-1:0] fld [11];
    logic [DIFF_W-1:0]        mag_next [3];
    logic [DIFF_W-1:0]        mag_reg  [3];
    ctx_t                     e0_next, e0_reg;
    logic                     e0_vld_reg;
    logic signed [DATA_W+1:0] fsum_w;
    logic [2:0]               fcnt;
    logic signed [DIFF_W-1:0] dd [3];

    always_comb begin
        for (int k = 0; k < 11; k++) begin
            fld[k] = s_tdata[LEN_W + DATA_W*k +: DATA_W];
        end
        for (int d = 0; d < 3; d++) begin
            dd[d] = DIFF_W'(fld[d]) - DIFF_W'(fld[d+3]);
            mag_next[d] = (d < int'(dim_reg) && d < MAX_DIMENSION) ?
                (dd[d][DIFF_W-1] ? DIFF_W'(-dd[d]) : DIFF_W'(dd[d])) : '0;
        end
        fcnt = (fcount_reg > 3'(MAX_FORCES)) ? 3'(MAX_FORCES) : fcount_reg;
        if (fcnt > 3'd4) begin
            fcnt = 3'd4;
        end
        fsum_w = '0;
        for (int k = 0; k < 4; k++) begin
            if (k < int'(fcnt)) begin
                fsum_w = fsum_w + (DATA_W+2)'(fld[6+k]);
            end
        end
        e0_next.len   = s_tdata[LEN_W-1:0];
        e0_next.deriv = fld[10];
        e0_next.fsum  = sat_s32(SAT_W'(fsum_w));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e0_vld_reg <= 1'b0;
        end else if (en) begin
            e0_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e0_reg  <= e0_next;
            mag_reg <= mag_next;
        end
    end

    // stage E1: squares
    logic [SQ_W-1:0] sq_reg [3];
    ctx_t            e1_reg;
    logic            e1_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_vld_reg <= 1'b0;
        end else if (en) begin
            e1_vld_reg <= e0_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_reg <= e0_reg;
            for (int d = 0; d < 3; d++) begin
                sq_reg[d] <= mag_reg[d] * mag_reg[d];
            end
        end
    end

    // stage E2: sum of squares
    sqrt_t sq_dat [NSQ+1];
    logic  sq_vld [NSQ+1];
    logic  e2_vld_reg;
    sqrt_t e2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e2_vld_reg <= 1'b0;
        end else if (en) begin
            e2_vld_reg <= e1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e2_reg.ctx  <= e1_reg;
            e2_reg.rad  <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            e2_reg.rem  <= '0;
            e2_reg.root <= '0;
        end
    end

    assign sq_vld[0] = e2_vld_reg;
    assign sq_dat[0] = e2_reg;

    for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
        wgst_sqrt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_vld  (sq_vld[i]),
            .in_data (sq_dat[i]),
            .out_vld (sq_vld[i+1]),
            .out_data(sq_dat[i+1])
        );
    end

    // stage D0: stretch numerator, overflow check, divider seed
    div_t                     d0_next, d0_reg;
    logic                     d0_vld_reg;
    logic signed [ROOT_W:0]   sdiff;
    logic [ROOT_W-1:0]        smag;
    logic [ROOT_W+FRAC_BITS-1:0] nwide;
    logic [HI_W-1:0]          nhi;

    always_comb begin
        sdiff = $signed({1'b0, sq_dat[NSQ].root})
              - $signed((ROOT_W+1)'(sq_dat[NSQ].ctx.len));
        smag  = sdiff[ROOT_W] ? ROOT_W'(-sdiff) : ROOT_W'(sdiff);
        nwide = {smag, {FRAC_BITS{1'b0}}};
        nhi   = nwide[ROOT_W+FRAC_BITS-1:Q_W];
        d0_next.ctx = sq_dat[NSQ].ctx;
        d0_next.neg = sdiff[ROOT_W];
        d0_next.ovf = {{(DREM_W-HI_W){1'b0}}, nhi}
                   >= {{(DREM_W-LEN_W){1'b0}}, sq_dat[NSQ].ctx.len};
        d0_next.rem = {{(DREM_W-HI_W){1'b0}}, nhi};
        d0_next.low = nwide[Q_W-1:0];
        d0_next.q   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d0_vld_reg <= 1'b0;
        end else if (en) begin
            d0_vld_reg <= sq_vld[NSQ];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d0_reg <= d0_next;
        end
    end

    div_t dv_dat [NDIV+1];
    logic dv_vld [NDIV+1];
    assign dv_vld[0] = d0_vld_reg;
    assign dv_dat[0] = d0_reg;

    for (genvar i = 0; i < NDIV; i++) begin : g_div
        wgst_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_vld  (dv_vld[i]),
            .in_data (dv_dat[i]),
            .out_vld (dv_vld[i+1]),
            .out_data(dv_dat[i+1])
        );
    end

    // stage F0: stress select and threshold compare
    div_t                      dvo;
    logic signed [DATA_W-1:0]  stretch_val, stress_next;
    logic signed [DATA_W:0]    excess_next;
    logic                      grew_next;
    logic signed [DATA_W-1:0]  f0_stress_reg;
    logic signed [DATA_W:0]    f0_excess_reg;
    logic                      f0_grew_reg, f0_vld_reg;
    ctx_t                      f0_ctx_reg;

    always_comb begin
        dvo = dv_dat[NDIV];
        if (dvo.ctx.len == '0) begin
            stretch_val = S32_MAX;
        end else if (dvo.ovf) begin
            stretch_val = dvo.neg ? S32_MIN : S32_MAX;
        end else if (!dvo.neg) begin
            stretch_val = dvo.q[Q_W-1] ? S32_MAX : $signed(dvo.q);
        end else begin
            stretch_val = dvo.q[Q_W-1] ? S32_MIN : -$signed(dvo.q);
        end
        stress_next = stretch_reg ? stretch_val : dvo.ctx.fsum;
        grew_next   = stress_next > thr_reg;
        excess_next = (DATA_W+1)'(stress_next) - (DATA_W+1)'(thr_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f0_vld_reg <= 1'b0;
        end else if (en) begin
            f0_vld_reg <= dv_vld[NDIV];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f0_stress_reg <= stress_next;
            f0_excess_reg <= excess_next;
            f0_grew_reg   <= grew_next;
            f0_ctx_reg    <= dvo.ctx;
        end
    end

    // stage F1: gain times excess
    logic signed [2*DATA_W:0]  prod1;
    logic signed [DATA_W-1:0]  f1_rate_reg, f1_stress_reg;
    logic                      f1_grew_reg, f1_vld_reg;
    ctx_t                      f1_ctx_reg;

    assign prod1 = (2*DATA_W+1)'(gain_reg) * (2*DATA_W+1)'(f0_excess_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
        end else if (en) begin
            f1_vld_reg <= f0_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_rate_reg   <= sat_s32(SAT_W'(prod1 >>> FRAC_BITS));
            f1_stress_reg <= f0_stress_reg;
            f1_grew_reg   <= f0_grew_reg;
            f1_ctx_reg    <= f0_ctx_reg;
        end
    end

    // stage F2: zero rate unless grew, optional length scaling
    localparam int R2_W = 2*DATA_W - FRAC_BITS;
    logic signed [2*DATA_W-1:0] prod2;
    logic signed [R2_W-1:0]     r2_next, f2_rate_reg;
    logic signed [DATA_W-1:0]   f2_stress_reg, f2_deriv_reg;
    logic                       f2_grew_reg, f2_vld_reg;

    always_comb begin
        prod2 = (2*DATA_W)'(f1_rate_reg) * $signed((2*DATA_W)'(f1_ctx_reg.len));
        if (!f1_grew_reg) begin
            r2_next = '0;
        end else if (scaled_reg) begin
            r2_next = R2_W'(prod2 >>> FRAC_BITS);
        end else begin
            r2_next = R2_W'(f1_rate_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f2_vld_reg <= 1'b0;
        end else if (en) begin
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f2_rate_reg   <= r2_next;
            f2_stress_reg <= f1_stress_reg;
            f2_deriv_reg  <= f1_ctx_reg.deriv;
            f2_grew_reg   <= f1_grew_reg;
        end
    end

    // stage F3: derivative sum, then output register with skid
    logic signed [DATA_W-1:0] deriv_fin;
    logic [64:0]              res_word;
    logic [64:0]              out_reg, skid_reg;

    assign deriv_fin = sat_s32(SAT_W'(f2_deriv_reg) + SAT_W'(f2_rate_reg));
    assign res_word  = {f2_grew_reg, f2_stress_reg, deriv_fin};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && m_tready) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= f2_vld_reg;
            end
        end else if (!out_valid_reg) begin
            out_valid_reg <= f2_vld_reg && en;
        end else if (f2_vld_reg && en) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_valid_reg && m_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : res_word;
        end else if (!out_valid_reg) begin
            out_reg <= res_word;
        end else if (en) begin
            skid_reg <= res_word;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg[63:0];
    assign m_tuser  = out_reg[64];

    `WGST_ASSERT_SAME(a_skid_has_out, skid_valid_reg, out_valid_reg, "skid full, output empty")
    `WGST_ASSERT_SAME(a_skid_stalls, skid_valid_reg, !s_tready, "input taken with full skid")
    `WGST_ASSERT_NEXT(a_out_holds, out_valid_reg && !m_tready, out_valid_reg,
                      "stalled result dropped")
endmodule
